### sv/tlb_pkg.sv
`timescale 1ns / 1ps

package tlb_pkg;

    // Default sizes of the buffer; the core takes these as its parameter defaults.
    localparam int TLB_ENTRIES_DEF = 8;
    localparam int FRAME_COUNT_DEF = 64;
    localparam int AGE_BITS_DEF    = 16;

    // Fixed field widths of the request and response beats.
    localparam int PROC_W  = 8;
    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 6;
    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 4;

    typedef enum logic [1:0] {
        ACT_LOOKUP,
        ACT_UPDATE,
        ACT_INVAL,
        ACT_FLUSH
    } action_t;

    typedef struct packed {
        action_t              action;
        logic [PROC_W-1:0]    proc_id;
        logic [PAGE_W-1:0]    page_number;
        logic [FRAME_W-1:0]   frame_in;
    } tlb_req_t;

    typedef struct packed {
        logic                 hit;
        logic [FRAME_W-1:0]   frame_out;
        logic [SLOT_W-1:0]    slot;
        logic                 replaced;
        logic [COUNT_W-1:0]   removed_count;
    } tlb_rsp_t;

    // Flags produced by the shared entry comparator for one entry.
    typedef struct packed {
        logic tag_hit;
        logic proc_hit;
        logic older;
    } cmp_flags_t;

    // Reduce an entry index to the width of the slot field.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [31:0] idx);
        return idx[SLOT_W-1:0];
    endfunction

    // Reduce an entry count to the width of the removed_count field.
    function automatic logic [COUNT_W-1:0] count_of(input logic [31:0] cnt);
        return cnt[COUNT_W-1:0];
    endfunction

endpackage

### sv/tlb_lru_tagged_core.sv
`timescale 1ns / 1ps

// Fully associative translation buffer, tagged by process id and page number,
// with per-entry saturating age counters for least-recently-used replacement.
// Requests arrive on the req channel and one response beat leaves on the rsp
// channel for every request beat; a beat moves when valid is high and stall
// is low. The block handles one request at a time: req_stall is high from
// the cycle after a request is taken until its response has been loaded into
// the output register. Entries live in a single-port-read memory that one
// shared comparator walks, one entry per cycle. A lookup, a refreshing
// update, an invalidate or a flush goes from accept to response through one
// scan pass over the memory, whose read data is registered, then a decision
// state and a hand-off state. An inserting update adds a second pass that
// writes back the aged counters and the new entry before the hand-off.
// A stalled response holds in the output register; the next request is taken
// meanwhile, and its response waits in the hand-off state until the register
// frees. Reset clears the valid bits, so the buffer starts empty and needs no
// clearing pass; the memory contents of invalid entries are never used.
module tlb_lru_tagged_core import tlb_pkg::*; #(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int AGE_BITS    = AGE_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  tlb_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output tlb_rsp_t rsp
);

    localparam int IDX_W  = $clog2(TLB_ENTRIES);
    localparam int CNT_W  = $clog2(TLB_ENTRIES + 1);
    localparam int WORD_W = PROC_W + PAGE_W + FRAME_W + AGE_BITS;

    localparam logic [CNT_W-1:0] ALL_CNT  = CNT_W'(TLB_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);
    localparam logic [16:0]      FRAME_LIMIT = 17'(FRAME_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_AGE,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    tlb_req_t               req_reg, req_next;
    logic [TLB_ENTRIES-1:0] valid_reg, valid_next;

    // Read sequencer: rd_cnt issues addresses, check_* marks the entry whose
    // data arrives from the memory this cycle.
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                   check_vld_reg, check_vld_next;
    logic [IDX_W-1:0]       check_idx_reg, check_idx_next;

    // Scan results.
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       match_idx_reg, match_idx_next;
    logic [FRAME_W-1:0]     match_frame_reg, match_frame_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]       oldest_idx_reg, oldest_idx_next;
    logic [AGE_BITS-1:0]    oldest_age_reg, oldest_age_next;
    logic [CNT_W-1:0]       flush_cnt_reg, flush_cnt_next;
    logic [IDX_W-1:0]       flush_first_reg, flush_first_next;
    logic [IDX_W-1:0]       victim_reg, victim_next;

    tlb_rsp_t               res_reg, res_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    tlb_rsp_t               rsp_reg, rsp_next;

    // Memory and comparator connections.
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [WORD_W-1:0]      rd_word;
    logic [PROC_W-1:0]      rd_proc;
    logic [PAGE_W-1:0]      rd_page;
    logic [FRAME_W-1:0]     rd_frame;
    logic [AGE_BITS-1:0]    rd_age;
    logic [AGE_BITS-1:0]    aged_age;
    cmp_flags_t             flags;

    logic                   last_check;
    logic                   frame_ok;
    logic [IDX_W-1:0]       victim_sel;
    logic [WORD_W-1:0]      new_word;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Entry word layout: proc, page, frame, age from the top bit down.
    assign rd_proc  = rd_word[WORD_W-1 -: PROC_W];
    assign rd_page  = rd_word[WORD_W-PROC_W-1 -: PAGE_W];
    assign rd_frame = rd_word[AGE_BITS +: FRAME_W];
    assign rd_age   = rd_word[AGE_BITS-1:0];

    assign ram_re     = (state_reg == S_SCAN || state_reg == S_AGE) && (rd_cnt_reg != ALL_CNT);
    assign last_check = check_vld_reg && (check_idx_reg == LAST_IDX);
    assign frame_ok   = (17'(req_reg.frame_in) < FRAME_LIMIT);
    assign victim_sel = free_found_reg ? free_idx_reg : oldest_idx_reg;
    assign new_word   = {req_reg.proc_id, req_reg.page_number, req_reg.frame_in,
                         {AGE_BITS{1'b0}}};

    tlb_entry_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TLB_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (rd_word)
    );

    tlb_age_cmp #(
        .AGE_BITS (AGE_BITS)
    ) u_cmp (
        .entry_valid (valid_reg[check_idx_reg]),
        .entry_proc  (rd_proc),
        .entry_page  (rd_page),
        .entry_age   (rd_age),
        .best_age    (oldest_age_reg),
        .req_proc    (req_reg.proc_id),
        .req_page    (req_reg.page_number),
        .flags       (flags),
        .aged_age    (aged_age)
    );

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        valid_next       = valid_reg;
        rd_cnt_next      = ram_re ? rd_cnt_reg + 1'b1 : rd_cnt_reg;
        check_vld_next   = ram_re;
        check_idx_next   = rd_cnt_reg[IDX_W-1:0];
        found_next       = found_reg;
        match_idx_next   = match_idx_reg;
        match_frame_next = match_frame_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        oldest_idx_next  = oldest_idx_reg;
        oldest_age_next  = oldest_age_reg;
        flush_cnt_next   = flush_cnt_reg;
        flush_first_next = flush_first_reg;
        victim_next      = victim_reg;
        res_next         = res_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg;
        ram_we           = 1'b0;
        ram_waddr        = check_idx_reg;
        ram_wdata        = new_word;

        // The output register empties when its beat is taken.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next         = req;
                    rd_cnt_next      = '0;
                    check_vld_next   = 1'b0;
                    found_next       = 1'b0;
                    free_found_next  = 1'b0;
                    oldest_idx_next  = '0;
                    oldest_age_next  = '0;
                    flush_cnt_next   = '0;
                    flush_first_next = '0;
                    state_next       = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (check_vld_reg)
                begin
                    if (flags.tag_hit && !found_reg)
                    begin
                        found_next       = 1'b1;
                        match_idx_next   = check_idx_reg;
                        match_frame_next = rd_frame;
                    end
                    if (!valid_reg[check_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = check_idx_reg;
                    end
                    // Oldest search on aged counters; ties keep the lower index.
                    if (check_idx_reg == '0 || flags.older)
                    begin
                        oldest_age_next = aged_age;
                        oldest_idx_next = check_idx_reg;
                    end
                    // A flush drops each entry of the process as the scan passes it.
                    if (req_reg.action == ACT_FLUSH && flags.proc_hit)
                    begin
                        valid_next[check_idx_reg] = 1'b0;
                        if (flush_cnt_reg == '0)
                        begin
                            flush_first_next = check_idx_reg;
                        end
                        flush_cnt_next = flush_cnt_reg + 1'b1;
                    end
                    if (last_check)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                res_next       = '0;
                rd_cnt_next    = '0;
                check_vld_next = 1'b0;
                state_next     = S_DONE;
                unique case (req_reg.action)
                    ACT_LOOKUP:
                    begin
                        if (found_reg)
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = match_idx_reg;
                            ram_wdata          = {req_reg.proc_id, req_reg.page_number,
                                                  match_frame_reg, {AGE_BITS{1'b0}}};
                            res_next.hit       = 1'b1;
                            res_next.frame_out = match_frame_reg;
                            res_next.slot      = slot_of(32'(match_idx_reg));
                        end
                    end
                    ACT_UPDATE:
                    begin
                        if (frame_ok && found_reg)
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = match_idx_reg;
                            ram_wdata     = new_word;
                            res_next.hit  = 1'b1;
                            res_next.slot = slot_of(32'(match_idx_reg));
                        end
                        else if (frame_ok)
                        begin
                            victim_next       = victim_sel;
                            res_next.replaced = 1'b1;
                            res_next.slot     = slot_of(32'(victim_sel));
                            state_next        = S_AGE;
                        end
                    end
                    ACT_INVAL:
                    begin
                        if (found_reg)
                        begin
                            valid_next[match_idx_reg] = 1'b0;
                            res_next.hit              = 1'b1;
                            res_next.slot             = slot_of(32'(match_idx_reg));
                            res_next.removed_count    = count_of(32'(1));
                        end
                    end
                    ACT_FLUSH:
                    begin
                        res_next.hit           = (flush_cnt_reg != '0);
                        res_next.slot          = slot_of(32'(flush_first_reg));
                        res_next.removed_count = count_of(32'(flush_cnt_reg));
                    end
                endcase
            end

            S_AGE:
            begin
                // Second pass: write back aged counters, and the new entry at the victim.
                if (check_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = check_idx_reg;
                    if (check_idx_reg == victim_reg)
                    begin
                        ram_wdata = new_word;
                    end
                    else
                    begin
                        ram_wdata = {rd_proc, rd_page, rd_frame, aged_age};
                    end
                    if (last_check)
                    begin
                        valid_next[victim_reg] = 1'b1;
                        state_next             = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            req_reg         <= '0;
            valid_reg       <= '0;
            rd_cnt_reg      <= '0;
            check_vld_reg   <= 1'b0;
            check_idx_reg   <= '0;
            found_reg       <= 1'b0;
            match_idx_reg   <= '0;
            match_frame_reg <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            oldest_idx_reg  <= '0;
            oldest_age_reg  <= '0;
            flush_cnt_reg   <= '0;
            flush_first_reg <= '0;
            victim_reg      <= '0;
            res_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            req_reg         <= req_next;
            valid_reg       <= valid_next;
            rd_cnt_reg      <= rd_cnt_next;
            check_vld_reg   <= check_vld_next;
            check_idx_reg   <= check_idx_next;
            found_reg       <= found_next;
            match_idx_reg   <= match_idx_next;
            match_frame_reg <= match_frame_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            oldest_idx_reg  <= oldest_idx_next;
            oldest_age_reg  <= oldest_age_next;
            flush_cnt_reg   <= flush_cnt_next;
            flush_first_reg <= flush_first_next;
            victim_reg      <= victim_next;
            res_reg         <= res_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_reg         <= rsp_next;
        end
    end

    // A taken request always starts a scan pass on the next cycle.
    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_SCAN))
        else $error("accepted request did not start a scan");

    // The memory pipeline is empty whenever the sequencer is idle.
    a_idle_no_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !check_vld_reg)
        else $error("read pipeline active while idle");

    // An insert never reports a hit.
    a_insert_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.hit && rsp.replaced))
        else $error("response reports both hit and replaced");

    // A nonzero frame only comes back on a lookup hit.
    a_frame_on_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.frame_out != '0) |->
            (rsp.hit && !rsp.replaced && rsp.removed_count == '0))
        else $error("frame returned outside a lookup hit");

    // Removed entries imply a reported hit.
    a_removed_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.removed_count != '0) |-> rsp.hit)
        else $error("entries removed without hit");

endmodule

### sv/tlb_entry_ram.sv
`timescale 1ns / 1ps

module tlb_entry_ram #(
    parameter int WIDTH  = 46,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/tlb_age_cmp.sv
`timescale 1ns / 1ps

module tlb_age_cmp import tlb_pkg::*; #(
    parameter int AGE_BITS = AGE_BITS_DEF
) (
    input  logic                entry_valid,
    input  logic [PROC_W-1:0]   entry_proc,
    input  logic [PAGE_W-1:0]   entry_page,
    input  logic [AGE_BITS-1:0] entry_age,
    input  logic [AGE_BITS-1:0] best_age,
    input  logic [PROC_W-1:0]   req_proc,
    input  logic [PAGE_W-1:0]   req_page,
    output cmp_flags_t          flags,
    output logic [AGE_BITS-1:0] aged_age
);

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    logic proc_eq;

    // Valid entries age by one and saturate at the top of the counter.
    assign aged_age = (entry_valid && entry_age != AGE_MAX) ? entry_age + 1'b1 : entry_age;

    assign proc_eq        = (entry_proc == req_proc);
    assign flags.proc_hit = entry_valid && proc_eq;
    assign flags.tag_hit  = entry_valid && proc_eq && (entry_page == req_page);
    assign flags.older    = (aged_age > best_age);

endmodule
